>>> design/rad_pkg.sv
// Package for the random access deque: field widths, stream packing,
// operation and status codes, and the classified command passed front to back.
// No dependencies.
package rad_pkg;

    localparam int OP_W    = 3;
    localparam int IDX_W   = 10;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 11;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ       = 3'd4,
        OP_WRITE      = 3'd5
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic             push;
        logic             pop;
        logic             at_front;
        logic             rd;
        logic             wr;
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] value;
    } cmd_t;

endpackage

>>> design/rad_front.sv
// Front end of the random access deque: accepts input transactions and
// classifies the operation code into command flags.
// Depends on rad_pkg.
module rad_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rad_pkg::S_TDATA_W-1:0] s_tdata,  // index[9:0], value[41:10], zero pad
    input  logic [rad_pkg::S_TUSER_W-1:0] s_tuser,  // op[2:0]
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output rad_pkg::cmd_t                 cmd
);
    import rad_pkg::*;

    assign s_tready  = cmd_ready;
    assign cmd_valid = s_tvalid;

    always_comb
    begin
        cmd          = '0;
        cmd.index    = s_tdata[IDX_W-1:0];
        cmd.value    = s_tdata[IDX_W+VAL_W-1:IDX_W];
        case (s_tuser[OP_W-1:0])
            OP_PUSH_FRONT:
            begin
                cmd.push     = 1'b1;
                cmd.at_front = 1'b1;
            end
            OP_PUSH_BACK:  cmd.push = 1'b1;
            OP_POP_FRONT:
            begin
                cmd.pop      = 1'b1;
                cmd.at_front = 1'b1;
            end
            OP_POP_BACK:   cmd.pop = 1'b1;
            OP_READ:       cmd.rd  = 1'b1;
            OP_WRITE:      cmd.wr  = 1'b1;
            default:       cmd.push = 1'b0;
        endcase
    end

endmodule

>>> design/rad_queue.sv
// Short command queue between front and back of the random access deque.
// Depends on rad_pkg.
module rad_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rad_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output rad_pkg::cmd_t out_cmd
);
    import rad_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign in_ready  = fill_reg != QCNT_W'(QUEUE_DEPTH);
    assign out_valid = fill_reg != '0;
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

>>> design/rad_back.sv
// Back end of the random access deque: ring pointer and count update,
// element store access, result stage and output register.
// Depends on rad_pkg.
module rad_back #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  rad_pkg::cmd_t                 cmd,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rad_pkg::M_TDATA_W-1:0] m_tdata,  // read_value[31:0], count[42:32], zero pad
    output logic [rad_pkg::M_TUSER_W-1:0] m_tuser   // status[1:0]
);
    import rad_pkg::*;

    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SUM_W = PW + 1;
    localparam int CMP_W = (CW > IDX_W) ? CW : IDX_W;
    localparam int EXT_W = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int RV_W  = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;
    localparam int PAD_W = M_TDATA_W - VAL_W - COUNT_W;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    logic [PW-1:0]      head_reg, head_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               p_valid_reg;
    logic [STAT_W-1:0]  p_status_reg;
    logic [CW-1:0]      p_count_reg;
    logic               p_rd_ok_reg;
    logic               m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TUSER_W-1:0] m_user_reg;

    logic               issue, p_adv;
    logic               full, empty, in_range;
    logic [CMP_W-1:0]   idx_w, cnt_w;
    logic [PW-1:0]      head_dec, head_inc, back_addr, idx_addr, addr;
    logic               mem_we, mem_re, rd_ok;
    status_t            status;
    logic [RV_W-1:0]    wr_ext, rv_ext;
    logic [EXT_W-1:0]   cnt_ext;
    logic [VAL_W-1:0]   rv;

    function automatic logic [PW-1:0] ring_wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] d;
        d = (s >= SUM_W'(DEPTH)) ? s - SUM_W'(DEPTH) : s;
        return d[PW-1:0];
    endfunction

    assign p_adv     = p_valid_reg && (!m_valid_reg || m_tready);
    assign cmd_ready = !p_valid_reg || p_adv;
    assign issue     = cmd_valid && cmd_ready;

    assign full     = cnt_reg == CW'(DEPTH);
    assign empty    = cnt_reg == '0;
    assign idx_w    = CMP_W'(cmd.index);
    assign cnt_w    = CMP_W'(cnt_reg);
    assign in_range = idx_w < cnt_w;
    assign head_dec = (head_reg == '0) ? PW'(DEPTH - 1) : head_reg - PW'(1);
    assign head_inc = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + PW'(1);
    assign back_addr = ring_wrap({1'b0, head_reg} + {1'b0, cnt_reg[PW-1:0]});
    assign idx_addr  = ring_wrap({1'b0, head_reg} + {1'b0, idx_w[PW-1:0]});
    assign wr_ext    = RV_W'(cmd.value);

    always_comb
    begin
        head_next = head_reg;
        cnt_next  = cnt_reg;
        status    = ST_OK;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        rd_ok     = 1'b0;
        addr      = head_reg;
        if (cmd.push)
        begin
            if (full)
            begin
                status = ST_FULL;
            end
            else
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                if (cmd.at_front)
                begin
                    head_next = head_dec;
                    addr      = head_dec;
                end
                else
                begin
                    addr = back_addr;
                end
            end
        end
        else if (cmd.pop)
        begin
            if (empty)
            begin
                status = ST_EMPTY;
            end
            else
            begin
                cnt_next = cnt_reg - CW'(1);
                if (cmd.at_front)
                begin
                    head_next = head_inc;
                end
            end
        end
        else if (cmd.rd || cmd.wr)
        begin
            if (!in_range)
            begin
                status = ST_RANGE;
            end
            else
            begin
                addr   = idx_addr;
                mem_we = cmd.wr;
                mem_re = cmd.rd;
                rd_ok  = cmd.rd;
            end
        end
        else
        begin
            status = ST_RANGE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue && mem_we)
        begin
            mem[addr] <= wr_ext[DATA_WIDTH-1:0];
        end
        if (issue && mem_re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rv_ext  = RV_W'(rdata_reg);
    assign rv      = p_rd_ok_reg ? rv_ext[VAL_W-1:0] : '0;
    assign cnt_ext = EXT_W'(p_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            cnt_reg     <= '0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                head_reg <= head_next;
                cnt_reg  <= cnt_next;
            end
            if (issue)
            begin
                p_valid_reg <= 1'b1;
            end
            else if (p_adv)
            begin
                p_valid_reg <= 1'b0;
            end
            if (p_adv)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            p_status_reg <= status;
            p_count_reg  <= cnt_next;
            p_rd_ok_reg  <= rd_ok;
        end
        if (p_adv)
        begin
            m_data_reg <= {{PAD_W{1'b0}}, cnt_ext[COUNT_W-1:0], rv};
            m_user_reg <= p_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

>>> design/random_access_deque_unit.sv
// Top level of the random access deque: front end, command queue and back end.
// Depends on rad_pkg, rad_front, rad_queue and rad_back.
//
//  channel | dir | tdata (low bit up)              | tuser
//  s_*     | in  | index[9:0], value[41:10]        | op[2:0]
//  m_*     | out | read_value[31:0], count[42:32]  | status[1:0]
//
// One transaction per cycle sustained while m_tready stays high; each operation uses
// the single element store port at most once, and a result passes through the command
// queue, the result stage and the output register. Reset clears the head pointer, the
// count and all valid flags; the element store is not cleared. A stalled m_tready fills
// the output register, the result stage and then the two-entry queue before s_tready drops.
module random_access_deque_unit #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rad_pkg::S_TDATA_W-1:0] s_tdata,  // index[9:0], value[41:10], zero pad
    input  logic [rad_pkg::S_TUSER_W-1:0] s_tuser,  // op[2:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rad_pkg::M_TDATA_W-1:0] m_tdata,  // read_value[31:0], count[42:32], zero pad
    output logic [rad_pkg::M_TUSER_W-1:0] m_tuser   // status[1:0]
);
    import rad_pkg::*;

    logic fq_valid, fq_ready;
    cmd_t fq_cmd;
    logic qb_valid, qb_ready;
    cmd_t qb_cmd;

    rad_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd       (fq_cmd)
    );

    rad_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    rad_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd       (qb_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

>>> dv/tb_random_access_deque_unit.sv
// Testbench for random_access_deque_unit: random and directed deque operations
// over the slave stream, results checked against a cycle-free deque predictor.
// Depends on rad_pkg and random_access_deque_unit.
`timescale 1ns / 100ps

module tb_random_access_deque_unit;

    localparam int DEPTH         = 1024;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int LATENCY_SLACK = 16;
    localparam int PRINT_CAP     = 100;

    localparam logic [rad_pkg::OP_W-1:0] OP_UNDEF_6 = 3'd6;
    localparam logic [rad_pkg::OP_W-1:0] OP_UNDEF_7 = 3'd7;

    typedef logic [rad_pkg::IDX_W-1:0] idx_t;

    typedef struct packed {
        logic [rad_pkg::OP_W-1:0]  op;
        logic [rad_pkg::IDX_W-1:0] index;
        logic [rad_pkg::VAL_W-1:0] value;
    } deque_cmd_t;

    typedef struct packed {
        logic [rad_pkg::VAL_W-1:0]   read_value;
        rad_pkg::status_t            status;
        logic [rad_pkg::COUNT_W-1:0] count;
    } deque_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [rad_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [rad_pkg::S_TUSER_W-1:0] s_tuser = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [rad_pkg::M_TDATA_W-1:0] m_tdata;
    logic [rad_pkg::M_TUSER_W-1:0] m_tuser;

    deque_cmd_t    pending_cmds[$];
    deque_result_t expected_results[$];
    deque_cmd_t    driven_cmd;

    logic [rad_pkg::VAL_W-1:0]   deque_store [0:DEPTH-1];
    logic [rad_pkg::IDX_W-1:0]   deque_head = '0;
    logic [rad_pkg::COUNT_W-1:0] deque_count = '0;

    int gen_count = 0;
    int queued_total = 0;
    int accepted_total = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int tx_idle_pct = 34;
    int rx_idle_pct = 62;

    random_access_deque_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic deque_result_t apply_to_deque(input deque_cmd_t c);
        deque_result_t           r;
        logic [rad_pkg::IDX_W-1:0] pos;
        r.read_value = '0;
        r.status     = rad_pkg::ST_OK;
        pos          = deque_head + c.index;
        case (c.op)
            rad_pkg::OP_PUSH_FRONT:
                if (deque_count == DEPTH)
                    r.status = rad_pkg::ST_FULL;
                else
                begin
                    deque_head = deque_head - 1'b1;
                    deque_store[deque_head] = c.value;
                    deque_count++;
                end
            rad_pkg::OP_PUSH_BACK:
                if (deque_count == DEPTH)
                    r.status = rad_pkg::ST_FULL;
                else
                begin
                    deque_store[deque_head + deque_count[rad_pkg::IDX_W-1:0]] = c.value;
                    deque_count++;
                end
            rad_pkg::OP_POP_FRONT:
                if (deque_count == 0)
                    r.status = rad_pkg::ST_EMPTY;
                else
                begin
                    deque_head = deque_head + 1'b1;
                    deque_count--;
                end
            rad_pkg::OP_POP_BACK:
                if (deque_count == 0)
                    r.status = rad_pkg::ST_EMPTY;
                else
                    deque_count--;
            rad_pkg::OP_READ:
                if ({1'b0, c.index} >= deque_count)
                    r.status = rad_pkg::ST_RANGE;
                else
                    r.read_value = deque_store[pos];
            rad_pkg::OP_WRITE:
                if ({1'b0, c.index} >= deque_count)
                    r.status = rad_pkg::ST_RANGE;
                else
                    deque_store[pos] = c.value;
            default:
                r.status = rad_pkg::ST_RANGE;
        endcase
        r.count = deque_count;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("%0t mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic add_cmd(input logic [rad_pkg::OP_W-1:0] op,
                           input logic [rad_pkg::IDX_W-1:0] index,
                           input logic [rad_pkg::VAL_W-1:0] value);
        deque_cmd_t c;
        c.op    = op;
        c.index = index;
        c.value = value;
        pending_cmds = {pending_cmds, c};
        queued_total++;
        if ((op == rad_pkg::OP_PUSH_FRONT || op == rad_pkg::OP_PUSH_BACK) && gen_count < DEPTH)
            gen_count++;
        if ((op == rad_pkg::OP_POP_FRONT || op == rad_pkg::OP_POP_BACK) && gen_count > 0)
            gen_count--;
    endtask

    function automatic logic [rad_pkg::VAL_W-1:0] random_value();
        int k;
        k = $urandom_range(11);
        case (k)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [rad_pkg::IDX_W-1:0] pick_index();
        int k;
        k = $urandom_range(9);
        if (gen_count != 0 && k < 5)
            return idx_t'($urandom_range(gen_count - 1));
        else if (k < 7)
            return idx_t'((gen_count >= DEPTH) ? DEPTH - 1 : gen_count);
        else
            return idx_t'($urandom_range(DEPTH - 1));
    endfunction

    task automatic add_mixed(input int n, input int push_pct, input int pop_pct);
        int                        r;
        int                        k;
        logic [rad_pkg::OP_W-1:0]  op;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            k = $urandom_range(19);
            if (r < push_pct)
                op = $urandom_range(1) ? rad_pkg::OP_PUSH_BACK : rad_pkg::OP_PUSH_FRONT;
            else if (r < push_pct + pop_pct)
                op = $urandom_range(1) ? rad_pkg::OP_POP_BACK : rad_pkg::OP_POP_FRONT;
            else if (k < 9)
                op = rad_pkg::OP_READ;
            else if (k < 18)
                op = rad_pkg::OP_WRITE;
            else
                op = (k == 18) ? OP_UNDEF_6 : OP_UNDEF_7;
            add_cmd(op, pick_index(), random_value());
        end
    endtask

    task automatic wait_for_quiet();
        do
            @(posedge clk);
        while (accepted_total != queued_total || expected_results.size() != 0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results = {expected_results, apply_to_deque(driven_cmd)};
                accepted_total++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    driven_cmd = pending_cmds[0];
                    pending_cmds.delete(0);
                    s_tvalid   <= 1'b1;
                    s_tdata    <= {6'b0, driven_cmd.value, driven_cmd.index};
                    s_tuser    <= driven_cmd.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        deque_result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", m_tdata[31:0], '0);
                else
                begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (m_tdata[31:0] !== want.read_value)
                        report_mismatch("read_value", m_tdata[31:0], want.read_value);
                    if (m_tuser[1:0] !== want.status)
                        report_mismatch("status", m_tuser[1:0], want.status);
                    if (m_tdata[42:32] !== want.count)
                        report_mismatch("count", m_tdata[42:32], want.count);
                end
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_random_access_deque_unit NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // pops, range errors and undefined ops on an empty deque, then pushes
        add_cmd(rad_pkg::OP_POP_FRONT, 10'd0, 32'h0);
        add_cmd(rad_pkg::OP_POP_BACK, 10'd0, 32'h0);
        add_cmd(rad_pkg::OP_READ, 10'd0, 32'h0);
        add_cmd(rad_pkg::OP_WRITE, 10'd0, 32'h1234_5678);
        add_cmd(OP_UNDEF_6, 10'd0, 32'h0);
        add_cmd(OP_UNDEF_7, 10'd1023, 32'hFFFF_FFFF);
        add_cmd(rad_pkg::OP_PUSH_BACK, 10'd0, 32'h7FFF_FFFF);
        add_cmd(rad_pkg::OP_PUSH_FRONT, 10'd1023, 32'h8000_0000);
        add_cmd(rad_pkg::OP_PUSH_BACK, 10'd0, 32'h0000_0000);
        add_cmd(rad_pkg::OP_PUSH_FRONT, 10'd0, 32'hFFFF_FFFF);
        add_cmd(rad_pkg::OP_READ, 10'd0, 32'h0);
        add_cmd(rad_pkg::OP_READ, 10'd3, 32'h0);
        add_cmd(rad_pkg::OP_READ, 10'd4, 32'h0);
        add_cmd(rad_pkg::OP_READ, 10'd1023, 32'h0);
        add_cmd(rad_pkg::OP_WRITE, 10'd1, 32'hAAAA_AAAA);
        add_cmd(rad_pkg::OP_WRITE, 10'd2, 32'h5555_5555);
        add_cmd(rad_pkg::OP_WRITE, 10'd1023, 32'h0);
        add_cmd(rad_pkg::OP_READ, 10'd1, 32'h0);
        add_cmd(rad_pkg::OP_READ, 10'd2, 32'h0);
        add_cmd(rad_pkg::OP_POP_FRONT, 10'd0, 32'h0);
        add_cmd(rad_pkg::OP_POP_BACK, 10'd0, 32'h0);
        add_cmd(rad_pkg::OP_READ, 10'd0, 32'h0);
        add_cmd(rad_pkg::OP_READ, 10'd1, 32'h0);
        // hold the sender until every result has drained
        wait_for_quiet();
        add_mixed(250, 30, 25);
        wait_for_quiet();

        tx_idle_pct = 62;
        rx_idle_pct = 34;
        // grow the deque well round the ring, then drain part way
        add_mixed(280, 70, 10);
        add_mixed(150, 10, 60);
        wait_for_quiet();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        add_mixed(150, 25, 45);
        wait_for_quiet();
        repeat (LATENCY_SLACK) @(posedge clk);

        if (expected_results.size() != 0)
            report_mismatch("missing results", '0, expected_results.size());
        if (mismatch_count == 0)
            $display("tb_random_access_deque_unit OK");
        else
            $display("tb_random_access_deque_unit NOT OK");
        $finish;
    end

endmodule
